// ----- rtl/jspwm_pkg.sv -----
// Shared types and constants for the joystick to three-channel PWM block.
// No dependencies; imported by every module of the block.
package jspwm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int PWM_PERIOD  = 87;

    localparam int CHAN_W     = 2;
    localparam int NUM_CHAN   = 3;
    localparam int PORT_W     = 2 * NUM_CHAN;
    localparam int PHASE_W    = 7;
    localparam int ON_W       = 9;
    localparam int LIMIT_W    = 10;
    localparam int OFFSET_W   = 9;
    localparam int GAIN_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [GAIN_W-1:0] GAIN_HORIZ = 16'd39322;
    localparam logic [GAIN_W-1:0] GAIN_VERT  = 16'd8258;
    localparam logic [ON_W-1:0]   ON_MAX     = 9'd511;

    localparam logic [CHAN_W-1:0] CHAN_VERT = 2'd2;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    localparam logic [CFG_ADDR_W-1:0] REG_HORIZ_REV_LIMIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HORIZ_FWD_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_REV_LIMIT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_FWD_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HORIZ_REV_OFFSET = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HORIZ_FWD_OFFSET = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_REV_OFFSET  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_FWD_OFFSET  = 3'd7;

    localparam logic [LIMIT_W-1:0]  RST_HORIZ_REV_LIMIT  = 10'd510;
    localparam logic [LIMIT_W-1:0]  RST_HORIZ_FWD_LIMIT  = 10'd514;
    localparam logic [LIMIT_W-1:0]  RST_VERT_REV_LIMIT   = 10'd465;
    localparam logic [LIMIT_W-1:0]  RST_VERT_FWD_LIMIT   = 10'd565;
    localparam logic [OFFSET_W-1:0] RST_HORIZ_REV_OFFSET = 9'd325;
    localparam logic [OFFSET_W-1:0] RST_HORIZ_FWD_OFFSET = 9'd288;
    localparam logic [OFFSET_W-1:0] RST_VERT_REV_OFFSET  = 9'd80;
    localparam logic [OFFSET_W-1:0] RST_VERT_FWD_OFFSET  = 9'd50;

    typedef logic [ON_W-1:0]  on_time_t;
    typedef logic [PHASE_W-1:0] step_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  horiz_rev_limit;
        logic [LIMIT_W-1:0]  horiz_fwd_limit;
        logic [LIMIT_W-1:0]  vert_rev_limit;
        logic [LIMIT_W-1:0]  vert_fwd_limit;
        logic [OFFSET_W-1:0] horiz_rev_offset;
        logic [OFFSET_W-1:0] horiz_fwd_offset;
        logic [OFFSET_W-1:0] vert_rev_offset;
        logic [OFFSET_W-1:0] vert_fwd_offset;
    } cfg_t;

endpackage

// ----- rtl/jspwm_cfg.sv -----
// Configuration register file: deadband limits and offsets.
// Depends on jspwm_pkg.
module jspwm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [jspwm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jspwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output jspwm_pkg::cfg_t                   cfg
);
    import jspwm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HORIZ_REV_LIMIT:  cfg_next.horiz_rev_limit  = cfg_wdata[LIMIT_W-1:0];
                REG_HORIZ_FWD_LIMIT:  cfg_next.horiz_fwd_limit  = cfg_wdata[LIMIT_W-1:0];
                REG_VERT_REV_LIMIT:   cfg_next.vert_rev_limit   = cfg_wdata[LIMIT_W-1:0];
                REG_VERT_FWD_LIMIT:   cfg_next.vert_fwd_limit   = cfg_wdata[LIMIT_W-1:0];
                REG_HORIZ_REV_OFFSET: cfg_next.horiz_rev_offset = cfg_wdata[OFFSET_W-1:0];
                REG_HORIZ_FWD_OFFSET: cfg_next.horiz_fwd_offset = cfg_wdata[OFFSET_W-1:0];
                REG_VERT_REV_OFFSET:  cfg_next.vert_rev_offset  = cfg_wdata[OFFSET_W-1:0];
                REG_VERT_FWD_OFFSET:  cfg_next.vert_fwd_offset  = cfg_wdata[OFFSET_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.horiz_rev_limit  <= RST_HORIZ_REV_LIMIT;
            cfg_reg.horiz_fwd_limit  <= RST_HORIZ_FWD_LIMIT;
            cfg_reg.vert_rev_limit   <= RST_VERT_REV_LIMIT;
            cfg_reg.vert_fwd_limit   <= RST_VERT_FWD_LIMIT;
            cfg_reg.horiz_rev_offset <= RST_HORIZ_REV_OFFSET;
            cfg_reg.horiz_fwd_offset <= RST_HORIZ_FWD_OFFSET;
            cfg_reg.vert_rev_offset  <= RST_VERT_REV_OFFSET;
            cfg_reg.vert_fwd_offset  <= RST_VERT_FWD_OFFSET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/jspwm_scale.sv -----
// Deadband, constant-gain scaling and saturation of one stick sample.
// Depends on jspwm_pkg.
module jspwm_scale (
    input  jspwm_pkg::cfg_t                    cfg,
    input  logic [jspwm_pkg::CHAN_W-1:0]       chan,
    input  logic [jspwm_pkg::SAMPLE_BITS-1:0]  sample,
    output jspwm_pkg::on_time_t                on_time,
    output logic                               forward
);
    import jspwm_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int CMP_W  = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
    localparam int BASE_W = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;
    localparam int DIFF_W = BASE_W + 2;

    logic                     is_vert;
    logic [GAIN_W-1:0]        gain;
    logic [LIMIT_W-1:0]       rev_lim;
    logic [LIMIT_W-1:0]       fwd_lim;
    logic [OFFSET_W-1:0]      rev_off;
    logic [OFFSET_W-1:0]      fwd_off;
    logic [PROD_W-1:0]        prod;
    logic [SAMPLE_BITS-1:0]   scaled;
    logic signed [DIFF_W-1:0] rev_diff;
    logic signed [DIFF_W-1:0] fwd_diff;
    logic                     below;
    logic                     above;

    function automatic on_time_t sat_on(input logic signed [DIFF_W-1:0] v);
        on_time_t r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(DIFF_W'(ON_MAX))) begin
            r = ON_MAX;
        end else begin
            r = v[ON_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        is_vert = (chan == CHAN_VERT);
        gain    = is_vert ? GAIN_VERT : GAIN_HORIZ;
        rev_lim = is_vert ? cfg.vert_rev_limit   : cfg.horiz_rev_limit;
        fwd_lim = is_vert ? cfg.vert_fwd_limit   : cfg.horiz_fwd_limit;
        rev_off = is_vert ? cfg.vert_rev_offset  : cfg.horiz_rev_offset;
        fwd_off = is_vert ? cfg.vert_fwd_offset  : cfg.horiz_fwd_offset;

        prod     = PROD_W'(sample) * PROD_W'(gain);
        scaled   = prod[PROD_W-1:GAIN_W];
        rev_diff = $signed(DIFF_W'(rev_off)) - $signed(DIFF_W'(scaled));
        fwd_diff = $signed(DIFF_W'(scaled)) - $signed(DIFF_W'(fwd_off));

        below = CMP_W'(sample) < CMP_W'(rev_lim);
        above = CMP_W'(sample) > CMP_W'(fwd_lim);

        if (below) begin
            on_time = sat_on(rev_diff);
            forward = 1'b0;
        end else if (above) begin
            on_time = sat_on(fwd_diff);
            forward = 1'b1;
        end else begin
            on_time = '0;
            forward = 1'b0;
        end
    end

endmodule

// ----- rtl/joystick_to_three_channel_pwm.sv -----
// Joystick to three-channel PWM: input register, pending/active store, period
// counter and result register. Depends on jspwm_pkg, jspwm_cfg, jspwm_scale.
// A tick yields a registered port word, a sample none; in/out registers decouple sides.
// Throughput: one item per cycle while no tick waits on an unaccepted port word.
// Reset (aresetn low, synchronous): registers to defaults, all on-times zero, step zero.
module joystick_to_three_channel_pwm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [jspwm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jspwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [jspwm_pkg::CHAN_W-1:0]      s_chan,
    input  logic [jspwm_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [jspwm_pkg::PORT_W-1:0]      m_port,
    output logic [jspwm_pkg::PHASE_W-1:0]     m_phase
);
    import jspwm_pkg::*;

    cfg_t cfg;

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [CHAN_W-1:0]      in_chan_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    on_time_t pend_on_reg  [NUM_CHAN];
    logic     pend_fwd_reg [NUM_CHAN];
    on_time_t act_on_reg   [NUM_CHAN];
    logic     act_fwd_reg  [NUM_CHAN];
    step_t    step_reg;
    step_t    step_next;

    logic              m_valid_reg;
    logic [PORT_W-1:0] m_port_reg;
    logic [PORT_W-1:0] port_next;
    step_t             m_phase_reg;

    on_time_t new_on;
    logic     new_fwd;
    logic     out_free;
    logic     stage_adv;
    logic     tick_adv;
    logic     sample_adv;
    logic     reload;

    jspwm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jspwm_scale u_scale (
        .cfg     (cfg),
        .chan    (in_chan_reg),
        .sample  (in_sample_reg),
        .on_time (new_on),
        .forward (new_fwd)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign stage_adv  = in_valid_reg && ((in_op_reg == OP_SAMPLE) || out_free);
    assign tick_adv   = stage_adv && (in_op_reg == OP_TICK);
    assign sample_adv = stage_adv && (in_op_reg == OP_SAMPLE)
                        && (32'(in_chan_reg) < NUM_CHAN);
    assign s_ready    = !in_valid_reg || stage_adv;
    assign reload     = (step_reg == '0);

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            port_next[2*k]   = reload ? pend_fwd_reg[k] : act_fwd_reg[k];
            port_next[2*k+1] = (reload ? pend_on_reg[k] : act_on_reg[k]) > ON_W'(step_reg);
        end
        if (32'(step_reg) + 1 >= PWM_PERIOD) begin
            step_next = '0;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg     <= s_op;
            in_chan_reg   <= s_chan;
            in_sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                pend_on_reg[k]  <= '0;
                pend_fwd_reg[k] <= 1'b0;
                act_on_reg[k]   <= '0;
                act_fwd_reg[k]  <= 1'b0;
            end
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (sample_adv) begin
                pend_on_reg[in_chan_reg]  <= new_on;
                pend_fwd_reg[in_chan_reg] <= new_fwd;
            end
            if (tick_adv) begin
                if (reload) begin
                    for (int k = 0; k < NUM_CHAN; k++) begin
                        act_on_reg[k]  <= pend_on_reg[k];
                        act_fwd_reg[k] <= pend_fwd_reg[k];
                    end
                end
                step_reg    <= step_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (tick_adv) begin
            m_port_reg  <= port_next;
            m_phase_reg <= step_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_port  = m_port_reg;
    assign m_phase = m_phase_reg;

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(step_reg) < PWM_PERIOD)
        else $error("period step out of range");

    a_phase_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_adv |=> (m_valid && m_phase == $past(step_reg)))
        else $error("result phase does not match step of the transfer");

    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_adv && step_reg != '0 |=> step_reg != '0 || $past(32'(step_reg)) == PWM_PERIOD - 1)
        else $error("period step wrapped early");

    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_adv && reload |=> act_on_reg[0] == $past(pend_on_reg[0])
                            && act_fwd_reg[2] == $past(pend_fwd_reg[2]))
        else $error("active values not reloaded at period start");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_op_reg == OP_TICK && !out_free)
        else $error("input stalled without a blocked tick");

endmodule

// ----- dv/joystick_to_three_channel_pwm_tb.sv -----
// Self-checking testbench for joystick_to_three_channel_pwm: drives stick samples
// and PWM ticks, predicts every port word and checks it. Depends on jspwm_pkg and
// the joystick_to_three_channel_pwm RTL.
`timescale 1ns / 1ps

module joystick_to_three_channel_pwm_tb;
    import jspwm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 29;

    typedef struct {
        op_t               op;
        logic [CHAN_W-1:0] chan;
        logic [SAMPLE_BITS-1:0] sample;
    } stick_t;

    typedef struct {
        logic [PORT_W-1:0] port;
        step_t             phase;
    } drive_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_op      = 1'b0;
    logic [CHAN_W-1:0]      s_chan    = '0;
    logic [SAMPLE_BITS-1:0] s_sample  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [PORT_W-1:0]      m_port;
    logic [PHASE_W-1:0]     m_phase;

    stick_t stick_q[$];
    drive_t port_q[$];
    int     errors       = 0;
    int     stall_cycles = 0;
    bit     no_idle      = 1'b0;

    cfg_t     ctl = '{RST_HORIZ_REV_LIMIT, RST_HORIZ_FWD_LIMIT, RST_VERT_REV_LIMIT,
                      RST_VERT_FWD_LIMIT, RST_HORIZ_REV_OFFSET, RST_HORIZ_FWD_OFFSET,
                      RST_VERT_REV_OFFSET, RST_VERT_FWD_OFFSET};
    on_time_t queued_on  [NUM_CHAN] = '{default: '0};
    logic     queued_fwd [NUM_CHAN] = '{default: 1'b0};
    on_time_t live_on    [NUM_CHAN] = '{default: '0};
    logic     live_fwd   [NUM_CHAN] = '{default: 1'b0};
    step_t    step_now = '0;

    joystick_to_three_channel_pwm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_chan    (s_chan),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_port    (m_port),
        .m_phase   (m_phase)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic thruster_model(input stick_t it);
        logic [LIMIT_W-1:0]          rev_lim, fwd_lim;
        logic [OFFSET_W-1:0]         rev_off, fwd_off;
        logic [GAIN_W-1:0]           gain;
        logic [SAMPLE_BITS+GAIN_W-1:0] prod;
        int     scaled, raw;
        drive_t d;
        if (it.op == OP_SAMPLE) begin
            if (it.chan > CHAN_VERT) return;
            if (it.chan == CHAN_VERT) begin
                rev_lim = ctl.vert_rev_limit;   fwd_lim = ctl.vert_fwd_limit;
                rev_off = ctl.vert_rev_offset;  fwd_off = ctl.vert_fwd_offset;
                gain    = GAIN_VERT;
            end else begin
                rev_lim = ctl.horiz_rev_limit;  fwd_lim = ctl.horiz_fwd_limit;
                rev_off = ctl.horiz_rev_offset; fwd_off = ctl.horiz_fwd_offset;
                gain    = GAIN_HORIZ;
            end
            prod   = it.sample * gain;
            scaled = int'(prod >> GAIN_W);
            if (it.sample < rev_lim) begin
                raw = int'(rev_off) - scaled;
                queued_fwd[it.chan] = 1'b0;
            end else if (it.sample > fwd_lim) begin
                raw = scaled - int'(fwd_off);
                queued_fwd[it.chan] = 1'b1;
            end else begin
                raw = 0;
                queued_fwd[it.chan] = 1'b0;
            end
            if (raw < 0)
                queued_on[it.chan] = '0;
            else if (raw > int'(ON_MAX))
                queued_on[it.chan] = ON_MAX;
            else
                queued_on[it.chan] = on_time_t'(raw);
        end else begin
            if (step_now == '0) begin
                live_on  = queued_on;
                live_fwd = queued_fwd;
            end
            d.port = '0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                d.port[2*k]   = live_fwd[k];
                d.port[2*k+1] = (live_on[k] > step_now);
            end
            d.phase = step_now;
            port_q.push_back(d);
            step_now = (step_now == step_t'(PWM_PERIOD - 1)) ? '0 : step_now + 1'b1;
        end
    endtask

    // Driver: hold each item until transfer, then advance.
    always @(posedge aclk) begin : driver
        stick_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.op = op_t'(s_op);
                it.chan = s_chan;
                it.sample = s_sample;
                thruster_model(it);
            end
            if (!s_valid || s_ready) begin
                if (stick_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    it = stick_q.pop_front();
                    s_valid  <= 1'b1;
                    s_op     <= it.op;
                    s_chan   <= it.chan;
                    s_sample <= it.sample;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each port word against the oldest prediction.
    always @(posedge aclk) begin : monitor
        drive_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (port_q.size() == 0) begin
                    flag("unexpected port word", m_port, -1);
                end else begin
                    want = port_q.pop_front();
                    if (m_port !== want.port)
                        flag("port", m_port, want.port);
                    if (m_phase !== want.phase)
                        flag("phase", m_phase, want.phase);
                end
            end
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_item(input op_t op, input int chan, input int sample);
        stick_t it;
        it.op     = op;
        it.chan   = chan[CHAN_W-1:0];
        it.sample = sample[SAMPLE_BITS-1:0];
        stick_q.push_back(it);
    endtask

    function automatic int pick_sample(input int chan);
        int lim;
        int v;
        case ($urandom_range(5))
            0: v = 0;
            1: v = (1 << SAMPLE_BITS) - 1;
            2: begin
                lim = (chan == CHAN_VERT) ? ctl.vert_rev_limit : ctl.horiz_rev_limit;
                v = lim + $urandom_range(4) - 2;
            end
            3: begin
                lim = (chan == CHAN_VERT) ? ctl.vert_fwd_limit : ctl.horiz_fwd_limit;
                v = lim + $urandom_range(4) - 2;
            end
            default: v = $urandom_range((1 << SAMPLE_BITS) - 1);
        endcase
        if (v < 0)
            v = 0;
        if (v > (1 << SAMPLE_BITS) - 1)
            v = (1 << SAMPLE_BITS) - 1;
        return v;
    endfunction

    // Ticks dominate so full periods pass; unused-channel samples are extra.
    task automatic queue_random(input int count);
        int n;
        int chan;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 62) begin
                push_item(OP_TICK, $urandom_range(3), $urandom_range(1023));
                n++;
            end else begin
                chan = ($urandom_range(99) < 95) ? $urandom_range(2) : 3;
                push_item(OP_SAMPLE, chan, pick_sample(chan));
                if (chan != 3)
                    n++;
            end
        end
    endtask

    // Wait until every item is transferred and every port word has arrived.
    task automatic settle();
        while (stick_q.size() != 0 || s_valid || port_q.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_HORIZ_REV_LIMIT:  ctl.horiz_rev_limit  = val[LIMIT_W-1:0];
            REG_HORIZ_FWD_LIMIT:  ctl.horiz_fwd_limit  = val[LIMIT_W-1:0];
            REG_VERT_REV_LIMIT:   ctl.vert_rev_limit   = val[LIMIT_W-1:0];
            REG_VERT_FWD_LIMIT:   ctl.vert_fwd_limit   = val[LIMIT_W-1:0];
            REG_HORIZ_REV_OFFSET: ctl.horiz_rev_offset = val[OFFSET_W-1:0];
            REG_HORIZ_FWD_OFFSET: ctl.horiz_fwd_offset = val[OFFSET_W-1:0];
            REG_VERT_REV_OFFSET:  ctl.vert_rev_offset  = val[OFFSET_W-1:0];
            REG_VERT_FWD_OFFSET:  ctl.vert_fwd_offset  = val[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int hrl, input int hfl, input int vrl, input int vfl,
                                 input int hro, input int hfo, input int vro, input int vfo);
        write_reg(REG_HORIZ_REV_LIMIT, hrl);
        write_reg(REG_HORIZ_FWD_LIMIT, hfl);
        write_reg(REG_VERT_REV_LIMIT, vrl);
        write_reg(REG_VERT_FWD_LIMIT, vfl);
        write_reg(REG_HORIZ_REV_OFFSET, hro);
        write_reg(REG_HORIZ_FWD_OFFSET, hfo);
        write_reg(REG_VERT_REV_OFFSET, vro);
        write_reg(REG_VERT_FWD_OFFSET, vfo);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: deadband edges, always-on drive, unused channel.
        push_item(OP_TICK, 0, 0);
        push_item(OP_SAMPLE, 0, 0);
        push_item(OP_SAMPLE, 1, 1023);
        push_item(OP_SAMPLE, 2, 0);
        push_item(OP_SAMPLE, 3, 1023);
        repeat (6) push_item(OP_TICK, 3, 1023);
        push_item(OP_SAMPLE, 0, 509);
        push_item(OP_SAMPLE, 1, 510);
        push_item(OP_SAMPLE, 2, 1023);
        push_item(OP_SAMPLE, 1, 514);
        push_item(OP_SAMPLE, 0, 515);
        push_item(OP_SAMPLE, 2, 565);
        push_item(OP_SAMPLE, 2, 464);
        repeat (6) push_item(OP_TICK, 0, 0);
        queue_random(180);
        settle();

        apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random(180);
        settle();

        apply_setting(1023, 1023, 1023, 1023, 511, 511, 511, 511);
        queue_random(180);
        settle();

        apply_setting($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(511), $urandom_range(511),
                      $urandom_range(511), $urandom_range(511));
        queue_random(180);
        settle();

        no_idle = 1'b1;
        apply_setting(RST_HORIZ_REV_LIMIT, RST_HORIZ_FWD_LIMIT, RST_VERT_REV_LIMIT,
                      RST_VERT_FWD_LIMIT, RST_HORIZ_REV_OFFSET, RST_HORIZ_FWD_OFFSET,
                      RST_VERT_REV_OFFSET, RST_VERT_FWD_OFFSET);
        queue_random(180);
        settle();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- joystick_to_three_channel_pwm.f -----
rtl/jspwm_pkg.sv
rtl/jspwm_cfg.sv
rtl/jspwm_scale.sv
rtl/joystick_to_three_channel_pwm.sv
dv/joystick_to_three_channel_pwm_tb.sv
